/* rtl/core/lmes_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lmes_pkg
// Shared widths, command and effect codes, register indexes and the
// control/status bundles between the scanner controller and datapath.
// ----------------------------------------------------------------------------
package lmes_pkg;

    localparam int CMD_W      = 3;
    localparam int EFF_W      = 2;
    localparam int ROW_W      = 4;
    localparam int PCOL_W     = 3;
    localparam int COL_W      = 8;
    localparam int ELAPSED_W  = 20;
    localparam int DUR_W      = 16;
    localparam int HALF_W     = 13;
    localparam int REP_W      = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SCAN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    localparam logic [EFF_W-1:0] EFF_NONE  = 2'd0;
    localparam logic [EFF_W-1:0] EFF_FILL  = 2'd1;
    localparam logic [EFF_W-1:0] EFF_FLASH = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_SCAN_DUR   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_HALF = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_REP  = 2'd2;

    localparam logic [DUR_W-1:0]  SCAN_DUR_RST   = 16'd2000;
    localparam logic [HALF_W-1:0] FLASH_HALF_RST = 13'd500;
    localparam logic [REP_W-1:0]  FLASH_REP_RST  = 4'd3;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 20'hFFFFF;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic prep;
        logic div_start;
        logic finish;
        logic flash_apply;
        logic fill_load;
        logic fill_row;
        logic elapsed_inc;
        logic out_load;
    } lmes_ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [EFF_W-1:0] effect;
        logic             bound_hit;
        logic             div_done;
        logic             fill_last;
        logic             out_free;
    } lmes_stat_t;

endpackage
`default_nettype wire

/* rtl/core/lmes_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lmes_ifs
// Valid/ready channels of the scanner: command items, result items and
// configuration writes.
// ----------------------------------------------------------------------------
interface lmes_item_if;
    import lmes_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [EFF_W-1:0]  effect_code;
    logic [ROW_W-1:0]  pixel_row;
    logic [PCOL_W-1:0] pixel_col;
    logic              pixel_on;

    modport source (output valid, command, effect_code, pixel_row, pixel_col, pixel_on,
                    input ready);
    modport sink   (input valid, command, effect_code, pixel_row, pixel_col, pixel_on,
                    output ready);
endinterface

interface lmes_result_if;
    import lmes_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_index;
    logic             row_drive;
    logic [COL_W-1:0] col_drive;
    logic             frame_end;
    logic [EFF_W-1:0] effect_now;

    modport source (output valid, row_index, row_drive, col_drive, frame_end, effect_now,
                    input ready);
    modport sink   (input valid, row_index, row_drive, col_drive, frame_end, effect_now,
                    output ready);
endinterface

interface lmes_cfg_if;
    import lmes_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/lmes_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lmes_div
// Restoring divider, one quotient bit per cycle, MSB first. The caller
// guarantees that the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
module lmes_div #(
    parameter int Q_W   = 8,
    parameter int DVS_W = 16,
    parameter int DIV_W = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [Q_W-1:0]        quotient
);
    localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0] shifted;
    logic             fits;

    assign shifted = DIV_W'(dvs_reg) << cnt_reg;
    assign fits    = (rem_reg >= shifted);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(Q_W - 1);
            rem_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - shifted;
            end
            quo_next = {quo_reg[Q_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

/* rtl/core/lmes_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lmes_dp
// Scanner datapath: pixel store, effect state, elapsed counter, config
// registers, effect arithmetic and the result register.
// ----------------------------------------------------------------------------
module lmes_dp #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lmes_pkg::lmes_ctl_t            ctl,
    output lmes_pkg::lmes_stat_t                stat,
    input  wire logic [lmes_pkg::CMD_W-1:0]     command,
    input  wire logic [lmes_pkg::EFF_W-1:0]     effect_code,
    input  wire logic [lmes_pkg::ROW_W-1:0]     pixel_row,
    input  wire logic [lmes_pkg::PCOL_W-1:0]    pixel_col,
    input  wire logic                           pixel_on,
    input  wire logic                           cfg_we,
    input  wire logic [lmes_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lmes_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [lmes_pkg::ROW_W-1:0]          row_index,
    output logic                                row_drive,
    output logic [lmes_pkg::COL_W-1:0]          col_drive,
    output logic                                frame_end,
    output logic [lmes_pkg::EFF_W-1:0]          effect_now
);
    import lmes_pkg::*;

    localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TOTAL  = ROWS * COLS;
    localparam int LIT_W  = $clog2(TOTAL + 1);
    localparam int Q_W    = (LIT_W > 5) ? LIT_W : 5;
    localparam int DIV_W  = DUR_W + Q_W;

    localparam logic [COL_W-1:0]  COL_MASK = COL_W'((1 << COLS) - 1);
    localparam logic [RIDX_W-1:0] LAST_ROW = RIDX_W'(ROWS - 1);
    localparam logic [LIT_W-1:0]  TOTAL_L  = LIT_W'(TOTAL);
    localparam logic [LIT_W-1:0]  COLS_L   = LIT_W'(COLS);

    // Config registers
    logic [DUR_W-1:0]  dur_reg;
    logic [HALF_W-1:0] half_reg;
    logic [REP_W-1:0]  rep_reg;

    // Latched item
    logic [CMD_W-1:0]  item_cmd_reg;
    logic [EFF_W-1:0]  item_code_reg;
    logic [ROW_W-1:0]  item_row_reg;
    logic [PCOL_W-1:0] item_col_reg;
    logic              item_on_reg;

    // Block state
    logic [COL_W-1:0]     rows_reg [ROWS];
    logic [EFF_W-1:0]     effect_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 display_on_reg;
    logic [RIDX_W-1:0]    scan_row_reg;

    // Effect work registers
    logic [DIV_W-1:0]  mul_reg;
    logic [LIT_W-1:0]  fill_rem_reg;
    logic [RIDX_W-1:0] row_ptr_reg;

    // Pending and presented result
    logic [ROW_W-1:0] res_row_reg;
    logic             res_drive_reg;
    logic [COL_W-1:0] res_cols_reg;
    logic             res_end_reg;
    logic             out_valid_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic             out_drive_reg;
    logic [COL_W-1:0] out_cols_reg;
    logic             out_end_reg;
    logic [EFF_W-1:0] out_eff_reg;

    logic              start_fx;
    logic              write_ok;
    logic [RIDX_W-1:0] rd_addr;
    logic [COL_W-1:0]  rd_word;
    logic [COL_W-1:0]  pix_bit;
    logic [DIV_W-1:0]  div_dividend;
    logic [DUR_W-1:0]  div_divisor;
    logic              div_done;
    logic [Q_W-1:0]    div_quo;
    logic [LIT_W-1:0]  lit;
    logic [3:0]        row_cnt;
    logic [3:0]        low_cnt;
    logic [COL_W:0]    low_ones;
    logic [COL_W-1:0]  fill_mask;
    logic              flash_off;

    assign start_fx = (item_code_reg == EFF_FILL) || (item_code_reg == EFF_FLASH);
    assign write_ok = (effect_reg == EFF_NONE)
                   && ({1'b0, item_row_reg} < (ROW_W + 1)'(ROWS))
                   && ({1'b0, item_col_reg} < (PCOL_W + 1)'(COLS));
    assign rd_addr  = (item_cmd_reg == CMD_SCAN) ? scan_row_reg : item_row_reg[RIDX_W-1:0];
    assign rd_word  = rows_reg[rd_addr];
    assign pix_bit  = COL_W'(1) << (PCOL_W'(COLS - 1) - item_col_reg);

    // Divider operands: fill divides lit count, flash finds the phase number
    assign div_dividend = (effect_reg == EFF_FILL) ? mul_reg : DIV_W'(elapsed_reg);
    assign div_divisor  = (effect_reg == EFF_FILL) ? dur_reg : DUR_W'(half_reg);

    lmes_div #(
        .Q_W   (Q_W),
        .DVS_W (DUR_W),
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Last step of the fill lights everything
    assign lit = ((elapsed_reg + 1'b1) == ELAPSED_W'(dur_reg)) ? TOTAL_L : LIT_W'(div_quo);
    assign flash_off = div_quo[0];

    // Lit pixels of the current row fill the high column pins
    assign row_cnt   = (fill_rem_reg >= COLS_L) ? 4'(COLS) : 4'(fill_rem_reg);
    assign low_cnt   = 4'(COLS) - row_cnt;
    assign low_ones  = ((COL_W + 1)'(1) << low_cnt) - 1'b1;
    assign fill_mask = COL_MASK & ~low_ones[COL_W-1:0];

    always_comb
    begin
        stat.cmd       = item_cmd_reg;
        stat.effect    = effect_reg;
        stat.bound_hit = (effect_reg == EFF_FILL) ? (elapsed_reg >= ELAPSED_W'(dur_reg))
                                                  : (DIV_W'(elapsed_reg) >= mul_reg);
        stat.div_done  = div_done;
        stat.fill_last = (row_ptr_reg == LAST_ROW);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg  <= SCAN_DUR_RST;
            half_reg <= FLASH_HALF_RST;
            rep_reg  <= FLASH_REP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SCAN_DUR:   dur_reg  <= cfg_data[DUR_W-1:0];
                REG_FLASH_HALF: half_reg <= cfg_data[HALF_W-1:0];
                REG_FLASH_REP:  rep_reg  <= cfg_data[REP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            item_cmd_reg  <= command;
            item_code_reg <= effect_code;
            item_row_reg  <= pixel_row;
            item_col_reg  <= pixel_col;
            item_on_reg   <= pixel_on;
        end
        if (ctl.prep)
        begin
            if (effect_reg == EFF_FILL)
            begin
                mul_reg <= DIV_W'(elapsed_reg[DUR_W-1:0]) * DIV_W'(TOTAL_L);
            end
            else
            begin
                mul_reg <= (DIV_W'(rep_reg) * DIV_W'(half_reg)) << 1;
            end
        end
        if (ctl.fill_load)
        begin
            fill_rem_reg <= lit;
            row_ptr_reg  <= '0;
        end
        else if (ctl.fill_row)
        begin
            fill_rem_reg <= fill_rem_reg - LIT_W'(row_cnt);
            row_ptr_reg  <= row_ptr_reg + 1'b1;
        end
        if (ctl.exec)
        begin
            if (item_cmd_reg == CMD_SCAN)
            begin
                res_row_reg   <= ROW_W'(scan_row_reg);
                res_end_reg   <= (scan_row_reg == LAST_ROW);
                res_drive_reg <= display_on_reg;
                res_cols_reg  <= display_on_reg ? (rd_word & COL_MASK) : '0;
            end
            else
            begin
                res_row_reg   <= '0;
                res_end_reg   <= 1'b0;
                res_drive_reg <= 1'b0;
                res_cols_reg  <= '0;
            end
        end
        if (ctl.out_load)
        begin
            out_row_reg   <= res_row_reg;
            out_drive_reg <= res_drive_reg;
            out_cols_reg  <= res_cols_reg;
            out_end_reg   <= res_end_reg;
            out_eff_reg   <= effect_reg;
        end
    end

    // Pixel store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                rows_reg[r] <= '0;
            end
        end
        else if (ctl.finish
                 || (ctl.exec && item_cmd_reg == CMD_CLEAR)
                 || (ctl.exec && item_cmd_reg == CMD_START && start_fx))
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                rows_reg[r] <= '0;
            end
        end
        else if (ctl.flash_apply)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                rows_reg[r] <= flash_off ? '0 : COL_MASK;
            end
        end
        else if (ctl.exec && item_cmd_reg == CMD_WRITE && write_ok)
        begin
            rows_reg[rd_addr] <= item_on_reg ? (rd_word | pix_bit) : (rd_word & ~pix_bit);
        end
        else if (ctl.fill_row)
        begin
            rows_reg[row_ptr_reg] <= fill_mask;
        end
    end

    // Effect mode, display enable, elapsed count, scan pointer, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_reg     <= EFF_NONE;
            display_on_reg <= 1'b1;
            elapsed_reg    <= '0;
            scan_row_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.exec && item_cmd_reg == CMD_START)
            begin
                if (item_code_reg == EFF_NONE)
                begin
                    effect_reg     <= EFF_NONE;
                    display_on_reg <= 1'b1;
                end
                else if (start_fx)
                begin
                    effect_reg     <= item_code_reg;
                    display_on_reg <= 1'b1;
                end
            end
            else if (ctl.finish || (ctl.exec && item_cmd_reg == CMD_CLEAR))
            begin
                effect_reg     <= EFF_NONE;
                display_on_reg <= 1'b1;
            end
            else if (ctl.fill_load)
            begin
                display_on_reg <= 1'b1;
            end
            else if (ctl.flash_apply)
            begin
                display_on_reg <= !flash_off;
            end

            if (ctl.exec && item_cmd_reg == CMD_START && start_fx)
            begin
                elapsed_reg <= '0;
            end
            else if (ctl.elapsed_inc && elapsed_reg != ELAPSED_MAX)
            begin
                elapsed_reg <= elapsed_reg + 1'b1;
            end

            if (ctl.exec && item_cmd_reg == CMD_SCAN)
            begin
                scan_row_reg <= (scan_row_reg == LAST_ROW) ? '0 : scan_row_reg + 1'b1;
            end

            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_index  = out_row_reg;
    assign row_drive  = out_drive_reg;
    assign col_drive  = out_cols_reg;
    assign frame_end  = out_end_reg;
    assign effect_now = out_eff_reg;

    a_finish_idle : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> (effect_reg == EFF_NONE) && display_on_reg)
        else $error("effect not stopped after finish");

    a_fill_used : assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.fill_row && row_ptr_reg == LAST_ROW) |=> (fill_rem_reg == '0))
        else $error("fill rebuild left pixels unplaced");

    a_frame_wrap : assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && item_cmd_reg == CMD_SCAN) |=> (res_end_reg == (scan_row_reg == '0)))
        else $error("frame end out of step with scan pointer");

endmodule
`default_nettype wire

/* rtl/core/lmes_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lmes_ctrl
// Sequencer for one item at a time: decode, effect arithmetic, divider wait,
// row rebuild and hand-off to the result register.
// ----------------------------------------------------------------------------
module lmes_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire lmes_pkg::lmes_stat_t stat,
    output lmes_pkg::lmes_ctl_t       ctl
);
    import lmes_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_APPLY = 3'd5;
    localparam logic [2:0] S_ROWS  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       fx_running;

    assign fx_running = (stat.effect == EFF_FILL) || (stat.effect == EFF_FLASH);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                if (stat.cmd == CMD_TICK && fx_running)
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    ctl.elapsed_inc = (stat.cmd == CMD_TICK);
                    state_next      = S_DONE;
                end
            end
            S_PREP:
            begin
                ctl.prep   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.bound_hit)
                begin
                    ctl.finish      = 1'b1;
                    ctl.elapsed_inc = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (stat.effect == EFF_FLASH)
                begin
                    ctl.flash_apply = 1'b1;
                    ctl.elapsed_inc = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    ctl.fill_load = 1'b1;
                    state_next    = S_ROWS;
                end
            end
            S_ROWS:
            begin
                ctl.fill_row = 1'b1;
                if (stat.fill_last)
                begin
                    ctl.elapsed_inc = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the result register can take the beat
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> stat.out_free)
        else $error("result loaded over an untaken beat");

    a_div_enter : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_start |=> (state_reg == S_DIV) && !stat.div_done)
        else $error("divider start not followed by wait");

    a_div_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !stat.div_done) |=> (state_reg == S_DIV))
        else $error("left divider wait early");

endmodule
`default_nettype wire

/* rtl/core/led_matrix_effect_scanner_top.sv */
// Sequencing: scan, write, start and clear items and a tick with no effect running go
//   from execute to result load; an effect tick adds prep, a bound check and, unless that
//   ends it, a Q-bit divide (Q = max(5, clog2(ROWS*COLS+1))) and a flash or fill step.
// Throughput: one item at a time; the serial divider gives one quotient bit a cycle, the
//   fill pattern is rebuilt one row a cycle; a new item is taken in the cycle after load.
// Reset: store, effect, elapsed count and scan row clear, display on, registers 2000/500/3.
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_effect_scanner_top
// Multiplexed LED matrix driver with fill and flash effects.
// ----------------------------------------------------------------------------
module led_matrix_effect_scanner_top #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lmes_item_if.sink   item,
    lmes_result_if.source result,
    lmes_cfg_if.sink    cfg
);
    import lmes_pkg::*;

    lmes_ctl_t  ctl;
    lmes_stat_t stat;

    assign cfg.ready = 1'b1;

    lmes_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .ctl        (ctl)
    );

    lmes_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .command     (item.command),
        .effect_code (item.effect_code),
        .pixel_row   (item.pixel_row),
        .pixel_col   (item.pixel_col),
        .pixel_on    (item.pixel_on),
        .cfg_we      (cfg.valid),
        .cfg_addr    (cfg.addr),
        .cfg_data    (cfg.data),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .row_index   (result.row_index),
        .row_drive   (result.row_drive),
        .col_drive   (result.col_drive),
        .frame_end   (result.frame_end),
        .effect_now  (result.effect_now)
    );

endmodule
`default_nettype wire

/* sim/matrix_scan_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_scan_checker
// Watches the command, result and register-write channels of the LED matrix
// scanner. Keeps its own copy of the pixel store, effect state and timing
// registers, predicts one result beat per accepted command beat, and compares
// each accepted result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module matrix_scan_checker #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic                            item_ready,
    input  logic [lmes_pkg::CMD_W-1:0]      command,
    input  logic [lmes_pkg::EFF_W-1:0]      effect_code,
    input  logic [lmes_pkg::ROW_W-1:0]      pixel_row,
    input  logic [lmes_pkg::PCOL_W-1:0]     pixel_col,
    input  logic                            pixel_on,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  logic [lmes_pkg::ROW_W-1:0]      row_index,
    input  logic                            row_drive,
    input  logic [lmes_pkg::COL_W-1:0]      col_drive,
    input  logic                            frame_end,
    input  logic [lmes_pkg::EFF_W-1:0]      effect_now,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lmes_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lmes_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              pending
);
    import lmes_pkg::*;

    localparam int PIXELS = ROWS * COLS;
    localparam int REPORT_MAX = 10;
    localparam logic [COL_W-1:0] COL_MASK = COL_W'((1 << COLS) - 1);

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic             row_drive;
        logic [COL_W-1:0] col_drive;
        logic             frame_end;
        logic [EFF_W-1:0] effect_now;
    } slot_out_t;

    logic [DUR_W-1:0]     scan_dur;
    logic [HALF_W-1:0]    flash_half;
    logic [REP_W-1:0]     flash_rep;
    logic [COL_W-1:0]     frame_buf [ROWS];
    logic [EFF_W-1:0]     effect_mode;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 lit_on;
    logic [ROW_W-1:0]     next_row;
    slot_out_t            slot_q [$];
    int                   fail_count;

    function automatic void blank_frame();
        for (int r = 0; r < ROWS; r++)
            frame_buf[r] = '0;
    endfunction

    function automatic void end_effect();
        blank_frame();
        effect_mode = EFF_NONE;
        lit_on = 1'b1;
    endfunction

    function automatic void fill_step();
        int unsigned el;
        int unsigned dur;
        int unsigned lit;
        el = 32'(elapsed);
        dur = 32'(scan_dur);
        if (el >= dur)
        begin
            end_effect();
        end
        else
        begin
            lit = (el * PIXELS) / dur;
            // light everything on the last tick of the fill
            if (lit < PIXELS && el >= dur - 1)
                lit = PIXELS;
            blank_frame();
            for (int unsigned k = 0; k < lit; k++)
                frame_buf[k / COLS][COLS - 1 - (k % COLS)] = 1'b1;
            lit_on = 1'b1;
        end
    endfunction

    function automatic void flash_step();
        int unsigned el;
        int unsigned half;
        int unsigned span;
        el = 32'(elapsed);
        half = 32'(flash_half);
        span = 32'(flash_rep);
        span = span * 2 * half;
        if (el >= span)
        begin
            end_effect();
        end
        else if (((el / half) & 1) == 0)
        begin
            lit_on = 1'b1;
            for (int r = 0; r < ROWS; r++)
                frame_buf[r] = COL_MASK;
        end
        else
        begin
            lit_on = 1'b0;
            blank_frame();
        end
    endfunction

    function automatic slot_out_t apply_command(input logic [CMD_W-1:0] cmd,
                                                input logic [EFF_W-1:0] code,
                                                input logic [ROW_W-1:0] prow,
                                                input logic [PCOL_W-1:0] pcol,
                                                input logic pon);
        slot_out_t   res;
        int unsigned r;
        res = '0;
        case (cmd)
            CMD_TICK:
            begin
                if (effect_mode == EFF_FILL)
                    fill_step();
                else if (effect_mode == EFF_FLASH)
                    flash_step();
                if (elapsed != ELAPSED_MAX)
                    elapsed = elapsed + 1'b1;
            end
            CMD_SCAN:
            begin
                r = next_row % ROWS;
                res.row_index = ROW_W'(r);
                res.frame_end = (r == ROWS - 1);
                if (lit_on)
                begin
                    res.row_drive = 1'b1;
                    res.col_drive = frame_buf[r] & COL_MASK;
                end
                next_row = ROW_W'((r + 1) % ROWS);
            end
            CMD_START:
            begin
                if (code == EFF_NONE)
                begin
                    effect_mode = EFF_NONE;
                    lit_on = 1'b1;
                end
                else if (code == EFF_FILL || code == EFF_FLASH)
                begin
                    blank_frame();
                    effect_mode = code;
                    elapsed = '0;
                    lit_on = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                if (effect_mode == EFF_NONE && prow < ROWS && pcol < COLS)
                    frame_buf[int'(prow)][COLS - 1 - int'(pcol)] = pon;
            end
            CMD_CLEAR: end_effect();
            default: ;
        endcase
        res.effect_now = effect_mode;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_out_t got;
        slot_out_t want;
        if (!rst_n)
        begin
            scan_dur = SCAN_DUR_RST;
            flash_half = FLASH_HALF_RST;
            flash_rep = FLASH_REP_RST;
            blank_frame();
            effect_mode = EFF_NONE;
            elapsed = '0;
            lit_on = 1'b1;
            next_row = '0;
            slot_q.delete();
            fail_count = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            // the result of this edge belongs to an earlier command: compare first
            if (res_valid && res_ready)
            begin
                got = {row_index, row_drive, col_drive, frame_end, effect_now};
                if (slot_q.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $display({"%0t: result beat with nothing pending: ",
                                  "row %0d drive %0b cols %02h end %0b effect %0d"},
                                 $realtime, got.row_index, got.row_drive, got.col_drive,
                                 got.frame_end, got.effect_now);
                    fail_count++;
                end
                else
                begin
                    want = slot_q.pop_front();
                    if (got.row_index !== want.row_index || got.row_drive !== want.row_drive ||
                        got.col_drive !== want.col_drive || got.frame_end !== want.frame_end ||
                        got.effect_now !== want.effect_now)
                    begin
                        if (fail_count < REPORT_MAX)
                        begin
                            $display("%0t: scan result differs", $realtime);
                            $display("    expected row %0d drive %0b cols %02h end %0b effect %0d",
                                     want.row_index, want.row_drive, want.col_drive,
                                     want.frame_end, want.effect_now);
                            $display("    actual   row %0d drive %0b cols %02h end %0b effect %0d",
                                     got.row_index, got.row_drive, got.col_drive,
                                     got.frame_end, got.effect_now);
                        end
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr)
                    REG_SCAN_DUR:   scan_dur = cfg_data[DUR_W-1:0];
                    REG_FLASH_HALF: flash_half = cfg_data[HALF_W-1:0];
                    REG_FLASH_REP:  flash_rep = cfg_data[REP_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
                slot_q.push_back(apply_command(command, effect_code, pixel_row,
                                               pixel_col, pixel_on));
            pending <= slot_q.size();
            mismatches <= fail_count;
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the LED matrix scanner with directed and random command streams
// (pixel painting, frame scans, fill and flash effects with timing register
// changes between rounds) under varying back-pressure, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import lmes_pkg::*;

    localparam int ROWS          = 8;
    localparam int COLS          = 8;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int ROUNDS        = 12;
    localparam int ROUND_ITEMS   = 118;
    localparam int TICK_CAP      = 40;

    localparam logic [EFF_W-1:0] EFF_UNUSED     = 2'd3;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI   = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int src_idle_pct;
    int sink_idle_pct;
    int item_count;
    int stall_cycles = 0;
    int mismatches;
    int pending;

    logic [DUR_W-1:0]  cur_dur;
    logic [HALF_W-1:0] cur_half;
    logic [REP_W-1:0]  cur_rep;

    lmes_item_if   item_ch ();
    lmes_result_if result_ch ();
    lmes_cfg_if    cfg_ch ();

    led_matrix_effect_scanner_top #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    matrix_scan_checker #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_ch.valid),
        .item_ready  (item_ch.ready),
        .command     (item_ch.command),
        .effect_code (item_ch.effect_code),
        .pixel_row   (item_ch.pixel_row),
        .pixel_col   (item_ch.pixel_col),
        .pixel_on    (item_ch.pixel_on),
        .res_valid   (result_ch.valid),
        .res_ready   (result_ch.ready),
        .row_index   (result_ch.row_index),
        .row_drive   (result_ch.row_drive),
        .col_drive   (result_ch.col_drive),
        .frame_end   (result_ch.frame_end),
        .effect_now  (result_ch.effect_now),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_addr    (cfg_ch.addr),
        .cfg_data    (cfg_ch.data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // end the run when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [EFF_W-1:0] code,
                                 input logic [ROW_W-1:0] prow, input logic [PCOL_W-1:0] pcol,
                                 input logic pon);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= cmd;
        item_ch.effect_code <= code;
        item_ch.pixel_row   <= prow;
        item_ch.pixel_col   <= pcol;
        item_ch.pixel_on    <= pon;
        do @(posedge clk); while (!item_ch.ready);
        item_count++;
    endtask

    task automatic issue_noise();
        issue_command(CMD_W'($urandom), EFF_W'($urandom), ROW_W'($urandom),
                      PCOL_W'($urandom), 1'($urandom));
    endtask

    task automatic issue_scan();
        issue_command(CMD_SCAN, EFF_W'($urandom), ROW_W'($urandom), PCOL_W'($urandom),
                      1'($urandom));
    endtask

    task automatic issue_tick();
        issue_command(CMD_TICK, EFF_W'($urandom), ROW_W'($urandom), PCOL_W'($urandom),
                      1'($urandom));
    endtask

    task automatic issue_pixel();
        logic [ROW_W-1:0] prow;
        // mostly rows that exist, now and then one beyond the matrix
        if ($urandom_range(0, 7) == 0)
            prow = ROW_W'($urandom_range(ROWS, 15));
        else
            prow = ROW_W'($urandom_range(0, ROWS - 1));
        issue_command(CMD_WRITE, EFF_W'($urandom), prow, PCOL_W'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [DUR_W-1:0] dur, input logic [HALF_W-1:0] half,
                              input logic [REP_W-1:0] rep);
        write_reg(REG_SCAN_DUR, CFG_DATA_W'(dur));
        write_reg(REG_FLASH_HALF, CFG_DATA_W'(half));
        write_reg(REG_FLASH_REP, CFG_DATA_W'(rep));
        cur_dur  = dur;
        cur_half = half;
        cur_rep  = rep;
    endtask

    task automatic paint_frame();
        repeat ($urandom_range(1, 12)) issue_pixel();
        repeat (ROWS) issue_scan();
        if ($urandom_range(0, 4) == 0)
            issue_command(CMD_CLEAR, EFF_W'($urandom), ROW_W'($urandom), PCOL_W'($urandom),
                          1'($urandom));
    endtask

    task automatic run_effect(input logic [EFF_W-1:0] code);
        int unsigned span;
        int          pick;
        if (code == EFF_FILL)
        begin
            span = 32'(cur_dur);
        end
        else
        begin
            span = 32'(cur_rep);
            span = span * 2 * 32'(cur_half);
        end
        // run just past the end of the effect, capped for long settings
        span = span + 1;
        if (span > TICK_CAP)
            span = TICK_CAP;
        span = span + $urandom_range(0, 2);
        issue_command(CMD_START, code, ROW_W'($urandom), PCOL_W'($urandom), 1'($urandom));
        repeat (span)
        begin
            issue_tick();
            pick = $urandom_range(0, 9);
            if (pick < 3)
                issue_scan();
            else if (pick == 3)
                issue_pixel();
        end
        pick = $urandom_range(0, 9);
        if (pick < 3)
            issue_command(CMD_CLEAR, code, ROW_W'($urandom), PCOL_W'($urandom), 1'($urandom));
        else if (pick < 5)
            issue_command(CMD_START, EFF_NONE, ROW_W'($urandom), PCOL_W'($urandom),
                          1'($urandom));
    endtask

    task automatic run_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            paint_frame();
        else if (pick < 65)
            run_effect(EFF_FILL);
        else if (pick < 85)
            run_effect(EFF_FLASH);
        else
            repeat ($urandom_range(1, 4)) issue_noise();
    endtask

    initial
    begin
        int base;
        int mode;
        item_ch.valid       = 1'b0;
        item_ch.command     = CMD_TICK;
        item_ch.effect_code = EFF_NONE;
        item_ch.pixel_row   = '0;
        item_ch.pixel_col   = '0;
        item_ch.pixel_on    = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.addr         = REG_SCAN_DUR;
        cfg_ch.data         = '0;
        result_ch.ready     = 1'b0;
        src_idle_pct        = 25;
        sink_idle_pct       = 73;
        item_count          = 0;
        cur_dur             = SCAN_DUR_RST;
        cur_half            = FLASH_HALF_RST;
        cur_rep             = FLASH_REP_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corners of the pixel store, out-of-range writes, a full frame
        issue_command(CMD_WRITE, EFF_NONE, '0, '0, 1'b1);
        issue_command(CMD_WRITE, EFF_NONE, ROW_W'(ROWS - 1), PCOL_W'(COLS - 1), 1'b1);
        issue_command(CMD_WRITE, EFF_NONE, 4'd15, 3'd7, 1'b1);
        issue_command(CMD_WRITE, EFF_NONE, '0, '0, 1'b0);
        repeat (ROWS) issue_scan();

        // unknown effect code and unused commands are dropped
        issue_command(CMD_START, EFF_UNUSED, '0, '0, 1'b0);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            issue_command(CMD_W'(c), EFF_FILL, 4'd15, 3'd7, 1'b1);

        // fill at reset timing, write while running, stop with code none
        issue_command(CMD_START, EFF_FILL, '0, '0, 1'b0);
        issue_tick();
        issue_tick();
        issue_command(CMD_WRITE, EFF_NONE, 4'd1, 3'd1, 1'b1);
        issue_command(CMD_START, EFF_NONE, '0, '0, 1'b0);
        issue_tick();
        issue_command(CMD_CLEAR, EFF_NONE, '0, '0, 1'b0);

        issue_command(CMD_START, EFF_FLASH, '0, '0, 1'b0);
        issue_tick();
        issue_command(CMD_CLEAR, EFF_NONE, '0, '0, 1'b0);

        // zero timing registers end each effect on its first tick
        drain();
        set_timing('0, '0, '0);
        issue_command(CMD_START, EFF_FILL, '0, '0, 1'b0);
        issue_tick();
        issue_command(CMD_START, EFF_FLASH, '0, '0, 1'b0);
        issue_tick();

        base = item_count;
        for (int round = 0; round < ROUNDS; round++)
        begin
            drain();
            mode = round * 3 / ROUNDS;
            if (mode == 0)
            begin
                src_idle_pct  = 25;
                sink_idle_pct = 73;
            end
            else if (mode == 1)
            begin
                src_idle_pct  = 73;
                sink_idle_pct = 25;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (round == 0)
                set_timing('1, '1, '1);
            else if (round == 1)
                set_timing(DUR_W'(1), HALF_W'(1), REP_W'(1));
            else if (round == ROUNDS - 1)
                set_timing(SCAN_DUR_RST, FLASH_HALF_RST, FLASH_REP_RST);
            else
                set_timing(DUR_W'($urandom_range(1, (round % 3 == 0) ? 400 : 24)),
                           HALF_W'($urandom_range(1, 6)), REP_W'($urandom_range(1, 4)));
            while (item_count < base + (round + 1) * ROUND_ITEMS)
                run_sequence();
        end

        drain();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
